// ===== design/rdlm_pkg.sv =====
// Shared constants, types and command/status structures of the level meter.
package rdlm_pkg;

    localparam int RING_DEPTH  = 1024;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int MAX_BLOCK   = 4096;
    localparam int CNT_W       = $clog2(MAX_BLOCK + 1);
    localparam int SAMPLE_BITS = 16;
    localparam int MAG_W       = SAMPLE_BITS + 1;
    localparam int ACC_W       = 44;
    localparam int EXP_W       = $clog2(ACC_W);
    localparam int FRAC_W      = 16;
    localparam int LG_W        = EXP_W + FRAC_W;
    localparam int MANT_W      = 32;
    localparam int ROUND_W     = $clog2(FRAC_W);
    localparam int FS2         = 2 * (SAMPLE_BITS - 1);
    localparam int D_W         = 24;
    localparam int SCALE_W     = 21;
    localparam int PROD_W      = D_W + SCALE_W;
    localparam int V_W         = PROD_W + 1;
    localparam int LEVEL_W     = 16;

    localparam logic signed [SCALE_W-1:0] LOG_SCALE = 21'sd841741;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_LOADA,
        ST_NORM,
        ST_SQR,
        ST_NEXT,
        ST_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic load_a;
        logic norm_shift;
        logic sq_load;
        logic sq_step;
        logic next_n;
        logic mul;
        logic fin;
        logic rd_cap;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic acc_zero;
        logic norm_done;
        logic sq_last;
        logic sel_n;
        logic out_free;
    } t_sts;

endpackage

// ===== design/rdlm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rdlm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rdlm_ctrl.sv =====
// Controller state machine sequencing accumulation, logarithm and ring access.
module rdlm_ctrl
    import rdlm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_cmd,
    input  logic i_last,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.take = i_valid;
                if (i_valid) begin
                    if (i_cmd) begin
                        n_state = ST_RD;
                    end else if (i_last) begin
                        n_state = ST_LOADA;
                    end
                end
            end
            ST_RD: begin
                o_cmd.rd_cap = 1'b1;
                n_state      = ST_DONE;
            end
            ST_LOADA: begin
                o_cmd.load_a = 1'b1;
                n_state      = i_sts.acc_zero ? ST_DONE : ST_NORM;
            end
            ST_NORM: begin
                if (i_sts.norm_done) begin
                    o_cmd.sq_load = 1'b1;
                    n_state       = ST_SQR;
                end else begin
                    o_cmd.norm_shift = 1'b1;
                end
            end
            ST_SQR: begin
                o_cmd.sq_step = 1'b1;
                if (i_sts.sq_last) begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (i_sts.sel_n) begin
                    o_cmd.mul = 1'b1;
                    n_state   = ST_FIN;
                end else begin
                    o_cmd.next_n = 1'b1;
                    n_state      = ST_NORM;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/rdlm_dp.sv =====
// Datapath: square accumulator, shared log2 unit, dB mapping, level ring and output register.
module rdlm_dp
    import rdlm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd_bus,
    output t_sts                      o_sts,
    input  logic                      i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [RING_AW-1:0]        i_age_index,
    input  logic                      i_ready,
    output logic                      o_valid,
    output logic [LEVEL_W-1:0]        o_level,
    output logic                      o_is_read
);

    logic [ACC_W-1:0]   r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic [ACC_W-1:0]   r_norm;
    logic [EXP_W-1:0]   r_exp;
    logic [MANT_W-1:0]  r_m;
    logic [FRAC_W-1:0]  r_frac;
    logic [ROUND_W-1:0] r_k;
    logic               r_sel;
    logic [LG_W-1:0]    r_lga;
    logic signed [PROD_W-1:0] r_prod;
    logic [LEVEL_W-1:0] r_level;
    logic               r_is_read;
    logic               r_rdok;
    logic               r_ovalid;
    logic [LEVEL_W-1:0] r_olevel;
    logic               r_ois_read;
    logic [RING_AW-1:0] r_wp;
    logic [RING_AW:0]   r_fill;

    logic [MAG_W-1:0]       w_s;
    logic [MAG_W-1:0]       w_mag;
    logic [2*MAG_W-1:0]     w_sq;
    logic [2*MANT_W-1:0]    w_p;
    logic signed [D_W-1:0]  w_d;
    logic signed [V_W-1:0]  w_v;
    logic signed [V_W-1:0]  w_vr;
    logic [LEVEL_W+4:0]     w_r;
    logic [RING_AW-1:0]     w_raddr;
    logic [LEVEL_W-1:0]     w_rdata;
    logic                   w_we;

    assign w_s   = {i_sample[SAMPLE_BITS-1], i_sample};
    assign w_mag = w_s[MAG_W-1] ? (MAG_W'(0) - w_s) : w_s;
    assign w_sq  = w_mag * w_mag;
    assign w_p   = r_m * r_m;

    assign w_d = $signed({2'b00, r_lga}) - $signed({2'b00, r_exp, r_frac})
               - $signed(D_W'(FS2 * 65536));
    assign w_v  = $signed({r_prod[PROD_W-1], r_prod}) + $signed(V_W'(64'd1 << 40));
    assign w_vr = w_v + $signed(V_W'(64'd1 << 23));
    assign w_r  = w_vr[V_W-2:24];

    // Ring address wraps naturally since the depth is a power of two.
    assign w_raddr = r_wp + i_age_index;
    assign w_we    = i_cmd_bus.emit && !r_is_read;

    rdlm_ram #(
        .WIDTH(LEVEL_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_wp),
        .i_wdata(r_level),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_sts.acc_zero  = (r_acc == '0);
    assign o_sts.norm_done = r_norm[ACC_W-1] || (r_exp == '0);
    assign o_sts.sq_last   = (r_k == ROUND_W'(FRAC_W - 1));
    assign o_sts.sel_n     = r_sel;
    assign o_sts.out_free  = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_cnt    <= '0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd_bus.take && !i_cmd && (r_cnt < CNT_W'(MAX_BLOCK))) begin
                r_acc <= r_acc + ACC_W'(w_sq);
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd_bus.emit) begin
                r_ovalid <= 1'b1;
                if (!r_is_read) begin
                    r_wp  <= r_wp + 1'b1;
                    r_acc <= '0;
                    r_cnt <= '0;
                    if (r_fill != (RING_AW+1)'(RING_DEPTH)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.take) begin
            r_is_read <= i_cmd;
            // Entries not yet written since reset read as zero.
            r_rdok <= (r_fill == (RING_AW+1)'(RING_DEPTH)) || ({1'b0, w_raddr} < r_fill);
        end
        if (i_cmd_bus.rd_cap) begin
            r_level <= r_rdok ? w_rdata : '0;
        end
        if (i_cmd_bus.load_a) begin
            r_norm  <= r_acc;
            r_exp   <= EXP_W'(ACC_W - 1);
            r_sel   <= 1'b0;
            r_level <= '0;
        end
        if (i_cmd_bus.norm_shift) begin
            r_norm <= r_norm << 1;
            r_exp  <= r_exp - 1'b1;
        end
        if (i_cmd_bus.sq_load) begin
            r_m    <= r_norm[ACC_W-1 -: MANT_W];
            r_frac <= '0;
            r_k    <= '0;
        end
        if (i_cmd_bus.sq_step) begin
            // One fraction bit per squaring of the mantissa.
            if (w_p[2*MANT_W-1]) begin
                r_m    <= w_p[2*MANT_W-1:MANT_W];
                r_frac <= {r_frac[FRAC_W-2:0], 1'b1};
            end else begin
                r_m    <= w_p[2*MANT_W-2:MANT_W-1];
                r_frac <= {r_frac[FRAC_W-2:0], 1'b0};
            end
            r_k <= r_k + 1'b1;
        end
        if (i_cmd_bus.next_n) begin
            r_lga  <= {r_exp, r_frac};
            r_norm <= ACC_W'(r_cnt);
            r_exp  <= EXP_W'(ACC_W - 1);
            r_sel  <= 1'b1;
        end
        if (i_cmd_bus.mul) begin
            r_prod <= PROD_W'(w_d * LOG_SCALE);
        end
        if (i_cmd_bus.fin) begin
            if (w_v[V_W-1] || (w_v == '0)) begin
                r_level <= '0;
            end else if (|w_r[LEVEL_W+4:LEVEL_W]) begin
                r_level <= '1;
            end else begin
                r_level <= w_r[LEVEL_W-1:0];
            end
        end
        if (i_cmd_bus.emit) begin
            r_olevel   <= r_level;
            r_ois_read <= r_is_read;
        end
    end

    assign o_valid   = r_ovalid;
    assign o_level   = r_olevel;
    assign o_is_read = r_ois_read;

endmodule

// ===== design/rms_db_level_meter_unit.sv =====
// Top level of the block RMS level meter with decibel scaling and level history ring.
// A sample request without the last mark is taken and leaves the block ready. A request
// with the last mark closes the block: the level is found by two passes of one shared log2
// unit (a normalising shift, then 16 squaring rounds each), a multiply and a rounding step;
// a silent block skips the log2 passes. A read request goes through the registered ring
// memory. A finished result waits in an output register and holds the block until the
// register is free; the block is not ready while it is busy with one request.
module rms_db_level_meter_unit
    import rdlm_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last,
    input  logic [RING_AW-1:0]            i_age_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [LEVEL_W-1:0]            o_level,
    output logic                          o_is_read
);

    t_cmd w_cmd;
    t_sts w_sts;

    rdlm_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_cmd  (i_cmd),
        .i_last (i_last),
        .o_ready(o_ready),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    rdlm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_bus  (w_cmd),
        .o_sts      (w_sts),
        .i_cmd      (i_cmd),
        .i_sample   (i_sample),
        .i_age_index(i_age_index),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_level    (o_level),
        .o_is_read  (o_is_read)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the block RMS decibel level meter and its history ring.
`timescale 1ns / 1ps

class level_scoreboard;
    longint unsigned energy_sum;
    int unsigned     sample_count;
    logic [15:0]     history [1024];
    int unsigned     head;
    logic [15:0]     pending_level [$];
    logic            pending_is_read [$];
    int              errors;

    function new();
        energy_sum   = 0;
        sample_count = 0;
        head         = 0;
        errors       = 0;
        foreach (history[k]) history[k] = '0;
    endfunction

    // Base-2 logarithm with 16 fraction bits, found by repeated squaring of the mantissa.
    function automatic longint log2_fix(longint unsigned x);
        int              e;
        longint unsigned m;
        longint          frac;
        e    = 63;
        frac = 0;
        while (e > 0 && x[e] == 1'b0) e--;
        m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
        for (int k = 0; k < 16; k++) begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'd4294967296) begin
                m    = m >> 1;
                frac = frac | 1;
            end
        end
        return longint'(e) * 65536 + frac;
    endfunction

    function automatic logic [15:0] decibel_level(longint unsigned acc, int unsigned n);
        longint d;
        longint v;
        longint r;
        if (acc == 0 || n == 0) return 16'd0;
        d = log2_fix(acc) - log2_fix(longint'(n)) - longint'(30) * 65536;
        v = (longint'(1) <<< 40) + d * longint'(841741);
        if (v <= 0) return 16'd0;
        r = (v + (longint'(1) <<< 23)) >>> 24;
        if (r > 65535) r = 65535;
        return r[15:0];
    endfunction

    function void note_request(logic cmd, logic signed [15:0] sample, logic last,
                               logic [9:0] age);
        longint mag;
        logic [15:0] lvl;
        if (cmd) begin
            pending_level   = {pending_level, history[(head + age) % 1024]};
            pending_is_read = {pending_is_read, 1'b1};
            return;
        end
        if (sample_count < 4096) begin
            mag = (sample < 0) ? -longint'(sample) : longint'(sample);
            energy_sum += mag * mag;
            sample_count++;
        end
        if (last) begin
            lvl = decibel_level(energy_sum, sample_count);
            history[head] = lvl;
            head = (head + 1) % 1024;
            energy_sum = 0;
            sample_count = 0;
            pending_level   = {pending_level, lvl};
            pending_is_read = {pending_is_read, 1'b0};
        end
    endfunction

    function void check_result(logic [15:0] level, logic is_read);
        logic [15:0] exp_level;
        logic        exp_is_read;
        if (pending_level.size() == 0) begin
            $error("unexpected result: level=%0d is_read=%0d", level, is_read);
            errors++;
            return;
        end
        exp_level   = pending_level.pop_front();
        exp_is_read = pending_is_read.pop_front();
        if (level !== exp_level) begin
            $error("level: expected %0d, actual %0d", exp_level, level);
            errors++;
        end
        if (is_read !== exp_is_read) begin
            $error("is_read: expected %0d, actual %0d", exp_is_read, is_read);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import rdlm_pkg::*;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic                          i_cmd;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic                          i_last;
    logic [RING_AW-1:0]            i_age_index;
    logic                          o_valid;
    logic                          i_ready;
    logic [LEVEL_W-1:0]            o_level;
    logic                          o_is_read;

    level_scoreboard sb;
    int     items_sent;
    int     results_seen;
    longint cycles = 0;

    rms_db_level_meter_unit DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** rms_db_level_meter_unit: FAILED **");
            $finish;
        end
    end

    function automatic int idle_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one request and holds it until taken, then idles for a random gap.
    task automatic send(logic cmd, logic signed [15:0] sample, logic last, logic [9:0] age);
        int gap;
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_sample    <= sample;
        i_last      <= last;
        i_age_index <= age;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(cmd, sample, last, age);
        items_sent++;
        gap = idle_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_block(int len, int shift);
        logic signed [15:0] s;
        for (int k = 0; k < len; k++) begin
            s = 16'($urandom);
            s = s >>> shift;
            if ($urandom_range(0, 19) == 0)
                send(CMD_READ, 16'($urandom), 1'($urandom), 10'($urandom));
            send(CMD_SAMPLE, s, k == len - 1, 10'($urandom));
        end
    endtask

    // Result side: random back-pressure, with one long hold-off so the block fills up.
    initial begin
        bit held;
        int p;
        held = 0;
        i_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && results_seen == 30) begin
                held = 1;
                i_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            p = $urandom_range(0, 99);
            if (results_seen > 100 && results_seen < 140) i_ready <= 1'b1;
            else if (p < 5) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end else i_ready <= (p < 75);
            @(posedge i_clk);
            if (i_ready && o_valid) begin
                sb.check_result(o_level, o_is_read);
                results_seen++;
            end
        end
    end

    initial begin
        int len;
        sb           = new();
        items_sent   = 0;
        results_seen = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_cmd       <= 1'b0;
        i_sample    <= '0;
        i_last      <= 1'b0;
        i_age_index <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: ring reads after reset, silence, full scale both ways, quiet floor.
        send(CMD_READ, 16'sh7fff, 1'b1, 10'd0);
        send(CMD_READ, 16'sh0000, 1'b0, 10'd1023);
        send(CMD_SAMPLE, 16'sh0000, 1'b1, 10'd0);
        send(CMD_SAMPLE, 16'sh8000, 1'b1, 10'd0);
        send(CMD_SAMPLE, 16'sh7fff, 1'b1, 10'h3ff);
        send(CMD_SAMPLE, -16'sd1, 1'b1, 10'd0);
        send(CMD_SAMPLE, 16'sd3, 1'b0, 10'd0);
        send(CMD_SAMPLE, 16'sd1, 1'b1, 10'd0);
        send(CMD_SAMPLE, 16'sd33, 1'b1, 10'd0);
        send(CMD_SAMPLE, 16'sd1000, 1'b0, 10'd0);
        send(CMD_READ, 16'sh5555, 1'b0, 10'd1023);
        send(CMD_SAMPLE, -16'sd1000, 1'b1, 10'd0);
        send(CMD_SAMPLE, 16'sh5555, 1'b1, 10'd0);
        send(CMD_SAMPLE, -16'sh2aab, 1'b1, 10'd0);
        for (int k = 0; k < 8; k++)
            send(CMD_READ, 16'sh0, 1'b0, 10'(1023 - k));
        send(CMD_READ, 16'sh0, 1'b0, 10'd512);

        // Random part: blocks of random length and loudness, with reads mixed in.
        while (items_sent < 1700) begin
            if ($urandom_range(0, 9) == 0) begin
                send(CMD_READ, 16'($urandom), 1'($urandom), 10'($urandom));
            end else begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 200)
                                                   : $urandom_range(1, 16);
                send_block(len, $urandom_range(0, 15));
            end
        end
        i_valid <= 1'b0;

        while (sb.pending_level.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) $display("** rms_db_level_meter_unit: PASSED **");
        else $display("** rms_db_level_meter_unit: FAILED **");
        $finish;
    end
endmodule

// ===== rms_db_level_meter_unit.f =====
design/rdlm_pkg.sv
design/rdlm_ram.sv
design/rdlm_ctrl.sv
design/rdlm_dp.sv
design/rms_db_level_meter_unit.sv
tb/tb_top.sv
